@@ hdl/psfc_pkg.sv @@
// ----------------------------------------------------------------------------
// PCM sample format converter package
// Conversion mode codes and shared types.
// ----------------------------------------------------------------------------
package psfc_pkg;

  typedef enum logic [3:0] {
    MODE_S16_F32 = 4'd0,
    MODE_S16_S32 = 4'd1,
    MODE_S24_F32 = 4'd2,
    MODE_S24_S32 = 4'd3,
    MODE_S24_S16 = 4'd4,
    MODE_S32_F32 = 4'd5,
    MODE_S32_S16 = 4'd6,
    MODE_F32_S32 = 4'd7,
    MODE_F32_S16 = 4'd8
  } mode_e;

  typedef enum logic [1:0] {
    KIND_ZERO = 2'd0,
    KIND_DIRECT = 2'd1,
    KIND_TO_FLOAT = 2'd2,
    KIND_TO_INT = 2'd3
  } kind_e;

endpackage

@@ hdl/pcm_sample_format_converter.sv @@
// ----------------------------------------------------------------------------
// PCM sample format converter
// Converts one PCM sample per transaction among s16, s24, s32 and f32.
// Pipeline: 4 register stages; output data and valid come from the last stage's registers.
// Throughput: one sample per cycle; a stall holds every stage in place.
// Reset: pipeline valid bits clear and conversion mode returns to s16->f32.
// ----------------------------------------------------------------------------
module pcm_sample_format_converter
  import psfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sample_out
  output logic        m_axis_tlast
);

  logic [3:0] mode_q;
  logic       adv;
  logic [3:0] v_q;

  assign cfg_ready_o   = 1'b1;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = v_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_S16_F32;
      v_q    <= '0;
    end else begin
      if (cfg_valid_i) mode_q <= cfg_data_i;
      if (adv) v_q <= {v_q[2:0], s_axis_tvalid};
    end
  end

  // Stage 1: classify and build a sign/magnitude with fixed point at bit 31
  logic        s1_last_q, s1_neg_q, s1_zero_q, s1_sat_q;
  logic [1:0]  s1_kind_q;
  logic [31:0] s1_direct_q;
  logic [31:0] s1_mag_q;
  logic [8:0]  s1_sc_q;
  logic        s1_to16_q, s1_round_int_q;

  logic        c_neg, c_zero, c_sat, c_to16, c_rint;
  logic [1:0]  c_kind;
  logic [31:0] c_dir, c_mag;
  logic [8:0]  c_sc;
  logic [31:0] x;
  logic [7:0]  fe;
  logic [23:0] fm;
  logic [16:0] nq;
  logic signed [33:0] nb;

  always_comb begin
    x = s_axis_tdata;
    fe = x[30:23];
    fm = {fe != 8'd0, x[22:0]};
    c_neg = 1'b0; c_zero = 1'b0; c_sat = 1'b0; c_to16 = 1'b0; c_rint = 1'b0;
    c_kind = KIND_ZERO; c_dir = '0; c_mag = '0; c_sc = '0;
    nb = '0; nq = '0;
    case (mode_q)
      MODE_S16_F32: begin
        c_kind = KIND_TO_FLOAT; c_neg = x[15];
        c_mag = {(x[15] ? 16'(-x[15:0]) : x[15:0]), 16'd0};
        c_zero = x[15:0] == 16'd0;
        if (x[15:0] == 16'h8000) c_mag = 32'h8000_0000;
      end
      MODE_S16_S32: begin c_kind = KIND_DIRECT; c_dir = {x[15:0], x[15:0]}; end
      MODE_S24_F32: begin
        c_kind = KIND_TO_FLOAT; c_neg = x[23];
        c_mag = {(x[23] ? 24'(-x[23:0]) : x[23:0]), 8'd0};
        c_zero = x[23:0] == 24'd0;
        if (x[23:0] == 24'h80_0000) c_mag = 32'h8000_0000;
      end
      MODE_S24_S32: begin c_kind = KIND_DIRECT; c_dir = {x[23:0], x[23:16]}; end
      MODE_S24_S16: begin
        c_kind = KIND_DIRECT;
        nb = 34'(signed'(x[23:0])) + 34'sd128;
        nq = nb[24:8];
        c_dir = {16'd0, (!nq[16] && nq[15]) ? 16'h7FFF : nq[15:0]};
      end
      MODE_S32_F32: begin
        c_kind = KIND_TO_FLOAT; c_neg = x[31];
        c_mag = x[31] ? -x : x;
        c_zero = x == 32'd0;
      end
      MODE_S32_S16: begin
        c_kind = KIND_DIRECT;
        nb = 34'(signed'(x)) + 34'sd32768;
        nq = nb[32:16];
        c_dir = {16'd0, (!nq[16] && nq[15]) ? 16'h7FFF : nq[15:0]};
      end
      MODE_F32_S32, MODE_F32_S16: begin
        c_kind = KIND_TO_INT; c_neg = x[31];
        c_to16 = mode_q == MODE_F32_S16;
        c_zero = (fe == 8'hFF && x[22:0] != 0) || fm == 24'd0;
        c_sat = fe == 8'hFF;
        c_mag = {fm, 8'd0};
        c_sc = {1'b0, fe};
        c_rint = 1'b1;
      end
      default: c_kind = KIND_ZERO;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_last_q <= s_axis_tlast; s1_neg_q <= c_neg; s1_zero_q <= c_zero;
      s1_sat_q <= c_sat; s1_kind_q <= c_kind; s1_direct_q <= c_dir;
      s1_mag_q <= c_mag; s1_sc_q <= c_sc; s1_to16_q <= c_to16;
      s1_round_int_q <= c_rint;
    end
  end

  // Stage 2: leading-one position and normalizing shift for int->float; float->int passes through
  logic        s2_last_q, s2_neg_q, s2_zero_q, s2_sat_q, s2_to16_q;
  logic [1:0]  s2_kind_q;
  logic [31:0] s2_direct_q, s2_mag_q;
  logic [4:0]  s2_lz_q;
  logic [8:0]  s2_sc_q;
  logic [4:0]  lz;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (s1_mag_q[i]) lz = 5'(31 - i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_last_q <= s1_last_q; s2_neg_q <= s1_neg_q; s2_zero_q <= s1_zero_q;
      s2_sat_q <= s1_sat_q; s2_to16_q <= s1_to16_q; s2_kind_q <= s1_kind_q;
      s2_direct_q <= s1_direct_q; s2_sc_q <= s1_sc_q;
      s2_mag_q <= s1_round_int_q ? s1_mag_q : (s1_mag_q << lz);
      s2_lz_q <= lz;
    end
  end

  // Stage 3: align; value = mag * 2^(sc - 158 + k) for float->int (mag has 8 low zeros)
  logic        s3_last_q, s3_neg_q, s3_zero_q, s3_sat_q, s3_to16_q;
  logic [1:0]  s3_kind_q;
  logic [31:0] s3_direct_q;
  logic [31:0] s3_int_q;
  logic        s3_g_q, s3_st_q;
  logic [30:0] s3_fm_q;
  logic [4:0]  s3_lz_q;
  logic [63:0] al;
  logic [9:0]  rsh;
  logic        big;
  logic [31:0] lost;

  always_comb begin
    // integer part = mag >> (158 - e - k); a negative shift means the
    // integer exceeds 32 bits -> saturate
    big = 1'b0; al = '0; lost = '0; rsh = '0;
    // rsh = right shift of {mag,32'b0} so that integer sits in al[63:32]
    if (s2_to16_q) rsh = 10'(10'd143 - {1'b0, s2_sc_q});
    else rsh = 10'(10'd127 - {1'b0, s2_sc_q});
    if (s2_sc_q == 9'd0) rsh = 10'(rsh - 10'd1);
    if (rsh[9]) big = 1'b1;
    else if (rsh > 10'd63) al = '0;
    else al = {s2_mag_q, 32'd0} >> rsh[5:0];
    if (!rsh[9] && rsh > 10'd63) lost = 32'd1;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_last_q <= s2_last_q; s3_neg_q <= s2_neg_q;
      s3_zero_q <= s2_zero_q; s3_sat_q <= s2_sat_q || big;
      s3_to16_q <= s2_to16_q; s3_kind_q <= s2_kind_q; s3_direct_q <= s2_direct_q;
      s3_int_q <= al[63:32]; s3_g_q <= al[31];
      s3_st_q <= (al[30:0] != 0) || (lost != 0);
      s3_fm_q <= s2_mag_q[30:0]; s3_lz_q <= s2_lz_q;
    end
  end

  // Stage 4: round, saturate, pack
  logic [31:0] s4_data_q;
  logic        s4_last_q;
  logic [32:0] ri, lim;
  logic [24:0] fk;
  logic [7:0]  fexp;
  logic [31:0] res, spos, sneg;
  logic [7:0]  bias;

  always_comb begin
    res = '0; ri = '0; fk = '0; fexp = '0;
    lim = s3_to16_q ? (s3_neg_q ? 33'd32768 : 33'd32767)
                    : (s3_neg_q ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF);
    spos = s3_to16_q ? 32'h0000_7FFF : 32'h7FFF_FFFF;
    sneg = s3_to16_q ? 32'h0000_8000 : 32'h8000_0000;
    bias = 8'd127;
    case (s3_kind_q)
      KIND_DIRECT: res = s3_direct_q;
      KIND_TO_FLOAT: begin
        fk = {1'b0, 1'b1, s3_fm_q[30:8]} + 25'(s3_fm_q[7] && (s3_fm_q[6:0] != 0
              || s3_fm_q[8]));
        fexp = 8'(bias - {3'd0, s3_lz_q});
        if (fk[24]) fexp = 8'(fexp + 8'd1);
        res = s3_zero_q ? 32'd0 : {s3_neg_q, fexp, fk[22:0]};
      end
      KIND_TO_INT: begin
        ri = {1'b0, s3_int_q} + 33'(s3_g_q && (s3_st_q || s3_int_q[0]));
        if (s3_zero_q) res = '0;
        else if (s3_sat_q || ri >= lim || ({1'b0, s3_int_q} >= lim))
          res = s3_neg_q ? sneg : spos;
        else res = s3_neg_q ? -ri[31:0] : ri[31:0];
        if (s3_to16_q) res = {16'd0, res[15:0]};
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_data_q <= res;
      s4_last_q <= s3_last_q;
    end
  end

  assign m_axis_tdata = s4_data_q;
  assign m_axis_tlast = s4_last_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s_axis_tvalid |-> ##1 v_q[0]) else $error("accepted item lost");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("stalled while empty");

endmodule
